>>> design/rgb_palette_indexer_assert.svh
// Assertion macros for the palette indexer RTL.
// Needs i_clk and i_rst_n in the module that uses them.
`ifndef RGB_PALETTE_INDEXER_ASSERT_SVH
`define RGB_PALETTE_INDEXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RGBPI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb palette indexer assertion failed");
`define RGBPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgb palette indexer assertion failed");
`else
`define RGBPI_ASSERT_SAME(label, ante, cons)
`define RGBPI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/rgbpi_pkg.sv
// Shared widths, search result struct and table size helpers.
// No dependencies.
package rgbpi_pkg;

    localparam int COLOR_W         = 24;
    localparam int CNT_W           = 9;
    localparam int IDX_W           = 8;
    localparam int CODE_W          = 4;
    localparam int MAX_ENTRIES_DEF = 256;

    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   idx;
        logic               is_new;
        logic               ovf;
        logic [CNT_W-1:0]   count;
    } t_srch_res;

    function automatic logic [CNT_W-1:0] table_for(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] t;
        t = CNT_W'(2);
        for (int k = 0; k < 7; k++) begin
            if (t < count) begin
                t = t << 1;
            end
        end
        return t;
    endfunction

    function automatic logic [CODE_W-1:0] code_for(input logic [CNT_W-1:0] tsize);
        logic [CODE_W-1:0] c;
        c = CODE_W'(2);
        for (int k = 2; k < CNT_W; k++) begin
            if (tsize[k]) begin
                c = CODE_W'(k);
            end
        end
        return c;
    endfunction

endpackage

>>> design/rgbpi_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module rgbpi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rgbpi_search.sv
// Search sequencer: walks the palette one entry per cycle through a shared compare.
// Depends on rgbpi_pkg, rgbpi_ram and rgb_palette_indexer_assert.svh.
`include "rgb_palette_indexer_assert.svh"
module rgbpi_search #(
    parameter int MAX_ENTRIES = rgbpi_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rgbpi_pkg::COLOR_W-1:0] i_color,
    input  logic                          i_first,
    output logic                          o_busy,
    output rgbpi_pkg::t_srch_res          o_res
);

    import rgbpi_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic               r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pend_idx, n_pend_idx;
    logic [COLOR_W-1:0] r_color, n_color;
    t_srch_res          r_res, n_res;

    logic               accept;
    logic               hit;
    logic               issue;
    logic               we;
    logic [COLOR_W-1:0] rdata;

    assign accept = i_start && (r_state == ST_IDLE);
    assign hit    = (r_state == ST_SEARCH) && r_pend && (rdata == r_color);
    assign issue  = (r_state == ST_SEARCH) && !hit && (r_idx < r_count);

    rgbpi_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_color),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_color    = r_color;
        n_res      = r_res;
        n_res.done = 1'b0;
        we         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SEARCH;
                    n_color = i_color;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    if (i_first) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (hit) begin
                    n_state      = ST_IDLE;
                    n_res.done   = 1'b1;
                    n_res.idx    = IDX_W'(r_pend_idx);
                    n_res.is_new = 1'b0;
                    n_res.ovf    = r_ovf;
                    n_res.count  = r_count;
                end else if (issue) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + CNT_W'(1);
                end else begin
                    n_state    = ST_IDLE;
                    n_res.done = 1'b1;
                    if (r_count < CNT_W'(MAX_ENTRIES)) begin
                        we           = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_res.idx    = IDX_W'(r_count[AW-1:0]);
                        n_res.is_new = 1'b1;
                        n_res.ovf    = r_ovf;
                        n_res.count  = r_count + CNT_W'(1);
                    end else begin
                        n_ovf        = 1'b1;
                        n_res.idx    = '0;
                        n_res.is_new = 1'b0;
                        n_res.ovf    = 1'b1;
                        n_res.count  = r_count;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_pend     <= 1'b0;
            r_res.done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_pend     <= n_pend;
            r_res.done <= n_res.done;
        end
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_color      <= n_color;
        r_res.idx    <= n_res.idx;
        r_res.is_new <= n_res.is_new;
        r_res.ovf    <= n_res.ovf;
        r_res.count  <= n_res.count;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_res  = r_res;

    `RGBPI_ASSERT_SAME(a_count_limit, 1'b1, r_count <= CNT_W'(MAX_ENTRIES))
    `RGBPI_ASSERT_NEXT(a_accept_search, accept, r_state == ST_SEARCH)
    `RGBPI_ASSERT_SAME(a_done_idle, r_res.done, r_state == ST_IDLE)
    `RGBPI_ASSERT_NEXT(a_write_new, we, r_res.done && r_res.is_new && !r_res.ovf)
    `RGBPI_ASSERT_SAME(a_read_in_range, issue, r_idx < r_count)

endmodule

>>> design/rgb_palette_indexer.sv
// Top level of the exact color palette indexer: search sequencer plus result register.
// Depends on rgbpi_pkg and rgbpi_search.
//
//  channel   handshake          payload
//  pixel in  start / busy       i_red, i_green, i_blue, i_first_pixel
//  result    o_valid (strobe)   o_color_index, o_is_new_color, o_overflow,
//                               o_color_count, o_table_size, o_min_code_size
//
// After a transfer busy stays high while the search runs: one palette
// read per cycle through a single RAM port and one shared compare.
// The result strobe rises in the cycle after busy falls, for one cycle.
// Synchronous reset clears the count and the overflow flag; the palette needs no clear.
// Results cannot be stalled.
module rgb_palette_indexer #(
    parameter int MAX_ENTRIES = rgbpi_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    input  logic                         i_first_pixel,
    output logic                         o_valid,
    output logic [rgbpi_pkg::IDX_W-1:0]  o_color_index,
    output logic                         o_is_new_color,
    output logic                         o_overflow,
    output logic [rgbpi_pkg::CNT_W-1:0]  o_color_count,
    output logic [rgbpi_pkg::CNT_W-1:0]  o_table_size,
    output logic [rgbpi_pkg::CODE_W-1:0] o_min_code_size
);

    import rgbpi_pkg::*;

    t_srch_res          res;
    logic [CNT_W-1:0]   tsize;

    logic               r_valid;
    logic [IDX_W-1:0]   r_index;
    logic               r_new;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_tsize;
    logic [CODE_W-1:0]  r_code;

    rgbpi_search #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_color ({i_red, i_green, i_blue}),
        .i_first (i_first_pixel),
        .o_busy  (busy),
        .o_res   (res)
    );

    assign tsize = table_for(res.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.done;
        end
        if (res.done) begin
            r_index <= res.idx;
            r_new   <= res.is_new;
            r_ovf   <= res.ovf;
            r_count <= res.count;
            r_tsize <= tsize;
            r_code  <= code_for(tsize);
        end
    end

    assign o_valid         = r_valid;
    assign o_color_index   = r_index;
    assign o_is_new_color  = r_new;
    assign o_overflow      = r_ovf;
    assign o_color_count   = r_count;
    assign o_table_size    = r_tsize;
    assign o_min_code_size = r_code;

endmodule
